@@ rtl/pcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pcd_pkg: shared constants for the point-to-capsule distance block
// Default widths, result width and configuration register indexes.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // default coordinate format, Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS
  localparam int PCD_COORD_WIDTH = 32;
  localparam int PCD_FRAC_BITS   = 16;

  // squared distance result is always this wide
  localparam int SQ_WIDTH = 63;

  // configuration register index
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENDPOINT_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LEN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CAPSULE_RAD   = 3'd7;

endpackage

@@ rtl/point_capsule_distance.sv @@
// ----------------------------------------------------------------------------
// point_capsule_distance: signed distance from a 3D point to a capsule
// Projects each point onto the capsule axis, picks cap A, cap B or side,
// forms the squared radial distance, takes a pipelined integer square root
// and returns signed gap, squared outside gap and a strict inside flag.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  in_     | slave     | in_tvalid/tready   | in_tdata: point_x, point_y,
//          |           |                    | point_z
//  out_    | master    | out_tvalid/tready  | out_tdata: signed_gap,
//          |           |                    | squared_gap, point_within
//  cfg_    | write     | cfg_we             | cfg_index, cfg_data
//
//  While in_tready is high one beat is taken per cycle; each gives one result.
//  The pipe has COORD_WIDTH + 11 register stages (43 at the default widths):
//  seven arithmetic stages, one square root stage per root bit
//  (COORD_WIDTH + 1), a saturate stage, a squaring stage and the output
//  register. The square root chain sets the depth.
//  Reset (rst_n low, synchronous) empties the pipe and loads the register
//  defaults: endpoint 0, axis +Z, length 0, radius 1.0.
//  A two-entry output buffer (output register plus skid register) parts the
//  sides; in_tready is registered and drops only while the skid entry holds,
//  which freezes the whole pipe while it holds, without losing a beat.
//
module point_capsule_distance #(
  parameter int COORD_WIDTH = pcd_pkg::PCD_COORD_WIDTH,
  parameter int FRAC_BITS   = pcd_pkg::PCD_FRAC_BITS
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // configuration write port
  input  logic                                          cfg_we,
  input  logic [pcd_pkg::CFG_IDX_W-1:0]                 cfg_index,
  input  logic [((COORD_WIDTH > FRAC_BITS + 2) ? COORD_WIDTH
                 : FRAC_BITS + 2)-1:0]                  cfg_data,
  // point stream
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // in_tdata, low bit up: point_x, point_y, point_z, zero fill to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]            in_tdata,
  // result stream
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // out_tdata, low bit up: signed_gap, squared_gap, point_within, zero fill
  output logic [((COORD_WIDTH+pcd_pkg::SQ_WIDTH+1+7)/8)*8-1:0] out_tdata
);

  import pcd_pkg::*;

  // --------------------------------------------------------------------------
  // widths
  // --------------------------------------------------------------------------
  localparam int CW    = COORD_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int DRW   = FB + 2;             // axis component
  localparam int LW    = CW - 1;             // length and radius
  localparam int NW    = CW + 1;             // p - A
  localparam int PRW   = DRW + NW;           // one axis product
  localparam int PSW   = PRW + 2;            // sum of three
  localparam int SW    = PSW - FB;           // projection s
  localparam int YW    = SW - 1;             // s - L beyond cap B, positive
  localparam int YHW   = YW - LW;            // upper slice of s - L
  localparam int NNW   = 2 * CW + 2;         // |p - A|^2
  localparam int QW    = YW + LW + 2;        // t^2 + 2 (s - L) L
  localparam int RW    = ((QW > NNW) ? QW : NNW) + 1;
  localparam int RTW   = NNW / 2;            // square root bits
  localparam int REMW  = RTW + 3;            // square root remainder
  localparam int GW    = CW + 2;             // unsaturated gap
  localparam int G2W   = 2 * (CW - 1);       // gap squared
  localparam int SQPW  = (G2W > SQ_WIDTH) ? G2W : SQ_WIDTH + 1;
  localparam int OUTW  = ((CW + SQ_WIDTH + 1 + 7) / 8) * 8;

  localparam logic signed [GW-1:0] GAP_MAX = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [GW-1:0] GAP_MIN = {3'b111, {(CW-1){1'b0}}};

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]  ep_r  [3];
  logic signed [DRW-1:0] dir_r [3];
  logic [LW-1:0]         len_r;
  logic [LW-1:0]         rad_r;
  logic [2*LW-1:0]       rr_r;               // radius squared

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r[0]  <= '0;
      ep_r[1]  <= '0;
      ep_r[2]  <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DRW'(1) << FB;
      len_r    <= '0;
      rad_r    <= LW'(1) << FB;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENDPOINT_X:  ep_r[0]  <= cfg_data[CW-1:0];
        REG_ENDPOINT_Y:  ep_r[1]  <= cfg_data[CW-1:0];
        REG_ENDPOINT_Z:  ep_r[2]  <= cfg_data[CW-1:0];
        REG_DIR_X:       dir_r[0] <= cfg_data[DRW-1:0];
        REG_DIR_Y:       dir_r[1] <= cfg_data[DRW-1:0];
        REG_DIR_Z:       dir_r[2] <= cfg_data[DRW-1:0];
        REG_SEGMENT_LEN: len_r    <= cfg_data[LW-1:0];
        REG_CAPSULE_RAD: rad_r    <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // radius squared is registered from the radius register; the user must
  // move config only while the pipe is empty, which the block does not enforce
  always_ff @(posedge clk) begin
    rr_r <= (2*LW)'(rad_r) * (2*LW)'(rad_r);
  end

  // --------------------------------------------------------------------------
  // flow control: whole pipe advances unless the skid entry is occupied
  // --------------------------------------------------------------------------
  logic en;
  logic skid_valid_r;
  logic out_valid_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  logic [6:0] pv_r;                          // valid of stages 1..7

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[5:0], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: offset from endpoint A
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] n_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= NW'($signed(in_tdata[i*CW +: CW])) - NW'(ep_r[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: axis products and squares
  // --------------------------------------------------------------------------
  logic signed [PRW-1:0]  pd_r   [3];
  logic [2*CW-1:0]        nsq_r  [3];
  logic signed [2*NW-1:0] nsq_full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsq_full[i] = (2*NW)'(n_r[i]) * (2*NW)'(n_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd_r[i]  <= PRW'(dir_r[i]) * PRW'(n_r[i]);
        nsq_r[i] <= nsq_full[i][2*CW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: sums; floor the projection back to FRAC_BITS
  // --------------------------------------------------------------------------
  logic signed [PSW-1:0] psum;
  logic signed [SW-1:0]  s_r;
  logic [NNW-1:0]        nn3_r;

  assign psum = PSW'(pd_r[0]) + PSW'(pd_r[1]) + PSW'(pd_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= psum[PSW-1:FB];
      nn3_r <= NNW'(nsq_r[0]) + NNW'(nsq_r[1]) + NNW'(nsq_r[2]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: region pick
  //   cap A: t = 0, y = 0        ra = nn
  //   side:  t = s, y = 0        ra = nn - s^2
  //   cap B: t = L, y = s - L    ra = nn - L^2 - 2 y L
  // --------------------------------------------------------------------------
  logic                 s_neg;
  logic                 s_beyond;
  logic signed [SW-1:0] s_less_len;
  logic [LW-1:0]        t_r;
  logic [YW-1:0]        y_r;
  logic [NNW-1:0]       nn4_r;

  assign s_neg      = s_r[SW-1];
  assign s_beyond   = s_r > $signed(SW'(len_r));
  assign s_less_len = s_r - $signed(SW'(len_r));

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_neg) begin
        t_r <= '0;
      end else if (s_beyond) begin
        t_r <= len_r;
      end else begin
        t_r <= s_r[LW-1:0];
      end
      y_r   <= s_beyond ? s_less_len[YW-1:0] : '0;
      nn4_r <= nn3_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: t^2 and y * L cut into a low and a high partial product
  // --------------------------------------------------------------------------
  logic [2*LW-1:0]    t2_r;
  logic [2*LW-1:0]    yll_r;
  logic [YHW+LW-1:0]  yhl_r;
  logic [NNW-1:0]     nn5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r  <= (2*LW)'(t_r) * (2*LW)'(t_r);
      yll_r <= (2*LW)'(y_r[LW-1:0]) * (2*LW)'(len_r);
      yhl_r <= (YHW+LW)'(y_r[YW-1:LW]) * (YHW+LW)'(len_r);
      nn5_r <= nn4_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: amount to take off nn
  // --------------------------------------------------------------------------
  logic [QW-1:0]  q_r;
  logic [NNW-1:0] nn6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= QW'(t2_r) + ((QW'(yll_r) + (QW'(yhl_r) << LW)) << 1);
      nn6_r <= nn5_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: radial distance squared, negative clamped to zero
  // --------------------------------------------------------------------------
  logic signed [RW-1:0] ra_diff;
  logic [NNW-1:0]       ra_r;

  assign ra_diff = $signed(RW'(nn6_r)) - $signed(RW'(q_r));

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r <= ra_diff[RW-1] ? '0 : ra_diff[NNW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // square root: one root bit per stage, restoring digit recurrence
  // --------------------------------------------------------------------------
  logic [RTW-1:0]  sq_v_r;
  logic [RTW-1:0]  sq_win_r;
  logic [RTW-1:0]  sq_win_in;
  logic [REMW-1:0] sq_rem_r   [RTW];
  logic [REMW-1:0] sq_rem_in  [RTW];
  logic [REMW-1:0] sq_rem_nxt [RTW];
  logic [RTW-1:0]  sq_root_r   [RTW];
  logic [RTW-1:0]  sq_root_in  [RTW];
  logic [RTW-1:0]  sq_root_nxt [RTW];
  logic [NNW-1:0]  sq_rdc_r   [RTW];
  logic [NNW-1:0]  sq_rdc_in  [RTW];
  logic [NNW-1:0]  sq_rdc_nxt [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_root
    logic [REMW-1:0] cur;
    logic [REMW-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign sq_rem_in[k]  = '0;
      assign sq_root_in[k] = '0;
      assign sq_rdc_in[k]  = ra_r;
      // strict inside test rides along with the root
      assign sq_win_in[k]  = ra_r < NNW'(rr_r);
    end else begin : g_next
      assign sq_rem_in[k]  = sq_rem_r[k-1];
      assign sq_root_in[k] = sq_root_r[k-1];
      assign sq_rdc_in[k]  = sq_rdc_r[k-1];
      assign sq_win_in[k]  = sq_win_r[k-1];
    end

    assign cur   = {sq_rem_in[k][REMW-3:0], sq_rdc_in[k][NNW-1:NNW-2]};
    assign trial = REMW'({sq_root_in[k], 2'b01});
    assign ge    = cur >= trial;

    assign sq_rem_nxt[k]  = ge ? cur - trial : cur;
    assign sq_root_nxt[k] = {sq_root_in[k][RTW-2:0], ge};
    assign sq_rdc_nxt[k]  = {sq_rdc_in[k][NNW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
    end else if (en) begin
      sq_v_r <= {sq_v_r[RTW-2:0], pv_r[6]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_win_r <= sq_win_in;
      for (int k = 0; k < RTW; k++) begin
        sq_rem_r[k]  <= sq_rem_nxt[k];
        sq_root_r[k] <= sq_root_nxt[k];
        sq_rdc_r[k]  <= sq_rdc_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // saturate stage: gap = sqrt(ra) - radius
  // --------------------------------------------------------------------------
  logic signed [GW-1:0] gap_full;
  logic                 gv_r;
  logic signed [CW-1:0] ggap_r;
  logic                 gwin_r;
  logic                 gpos_r;

  assign gap_full = $signed(GW'(sq_root_r[RTW-1])) - $signed(GW'(rad_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv_r <= 1'b0;
    end else if (en) begin
      gv_r <= sq_v_r[RTW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (gap_full > GAP_MAX) begin
        ggap_r <= GAP_MAX[CW-1:0];
      end else if (gap_full < GAP_MIN) begin
        ggap_r <= GAP_MIN[CW-1:0];
      end else begin
        ggap_r <= gap_full[CW-1:0];
      end
      gwin_r <= sq_win_r[RTW-1];
      // outside and strictly positive: squared gap is reported
      gpos_r <= !sq_win_r[RTW-1] && !gap_full[GW-1] && (gap_full != '0);
    end
  end

  // --------------------------------------------------------------------------
  // squaring stage
  // --------------------------------------------------------------------------
  logic                 mv_r;
  logic [G2W-1:0]       g2_r;
  logic signed [CW-1:0] mgap_r;
  logic                 mwin_r;
  logic                 mpos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (en) begin
      mv_r <= gv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g2_r   <= G2W'(ggap_r[CW-2:0]) * G2W'(ggap_r[CW-2:0]);
      mgap_r <= ggap_r;
      mwin_r <= gwin_r;
      mpos_r <= gpos_r;
    end
  end

  // clamp the square to the result width
  logic [SQPW-1:0]     g2_ext;
  logic                g2_over;
  logic [SQ_WIDTH-1:0] res_sq;
  logic                push;

  assign g2_ext  = SQPW'(g2_r);
  assign g2_over = |g2_ext[SQPW-1:SQ_WIDTH];
  assign res_sq  = !mpos_r ? '0 : (g2_over ? {SQ_WIDTH{1'b1}} : g2_ext[SQ_WIDTH-1:0]);
  assign push    = en && mv_r;

  // --------------------------------------------------------------------------
  // output register and skid entry
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] out_gap_r;
  logic [SQ_WIDTH-1:0]  out_sq_r;
  logic                 out_within_r;
  logic signed [CW-1:0] skid_gap_r;
  logic [SQ_WIDTH-1:0]  skid_sq_r;
  logic                 skid_within_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      // output held: park the beat leaving the pipe
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_gap_r    <= skid_gap_r;
        out_sq_r     <= skid_sq_r;
        out_within_r <= skid_within_r;
      end else begin
        out_gap_r    <= mgap_r;
        out_sq_r     <= res_sq;
        out_within_r <= mwin_r;
      end
    end else if (push) begin
      skid_gap_r    <= mgap_r;
      skid_sq_r     <= res_sq;
      skid_within_r <= mwin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUTW'({out_within_r, out_sq_r, out_gap_r});

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a beat while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid entry filled without a stalled output");

  a_inside_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_within_r) |-> out_gap_r[CW-1])
    else $error("inside point with a non-negative signed gap");

  a_square_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_sq_r != '0)) |->
      (!out_within_r && !out_gap_r[CW-1] && (out_gap_r != '0)))
    else $error("nonzero squared gap for a point that is not outside");
`endif

endmodule
